// ===== rtl/assert_macros.svh =====
// Assertion helpers used by sha224_stream_hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/s224_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s224_pkg
// Shared types, constants and round functions of the SHA-224 stream hasher.
// ---------------------------------------------------------------------------
package s224_pkg;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last;
  } out_item_t;

  // classified transaction handed from front to back
  typedef struct packed {
    logic       is_finish;
    logic [7:0] data_byte;
  } work_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic       compressing;
    logic [5:0] round;
  } core_status_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
    32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big0(input logic [31:0] x);
    big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428A2F98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hB5C0FBCF;  6'd3:  round_k = 32'hE9B5DBA5;
      6'd4:  round_k = 32'h3956C25B;  6'd5:  round_k = 32'h59F111F1;
      6'd6:  round_k = 32'h923F82A4;  6'd7:  round_k = 32'hAB1C5ED5;
      6'd8:  round_k = 32'hD807AA98;  6'd9:  round_k = 32'h12835B01;
      6'd10: round_k = 32'h243185BE;  6'd11: round_k = 32'h550C7DC3;
      6'd12: round_k = 32'h72BE5D74;  6'd13: round_k = 32'h80DEB1FE;
      6'd14: round_k = 32'h9BDC06A7;  6'd15: round_k = 32'hC19BF174;
      6'd16: round_k = 32'hE49B69C1;  6'd17: round_k = 32'hEFBE4786;
      6'd18: round_k = 32'h0FC19DC6;  6'd19: round_k = 32'h240CA1CC;
      6'd20: round_k = 32'h2DE92C6F;  6'd21: round_k = 32'h4A7484AA;
      6'd22: round_k = 32'h5CB0A9DC;  6'd23: round_k = 32'h76F988DA;
      6'd24: round_k = 32'h983E5152;  6'd25: round_k = 32'hA831C66D;
      6'd26: round_k = 32'hB00327C8;  6'd27: round_k = 32'hBF597FC7;
      6'd28: round_k = 32'hC6E00BF3;  6'd29: round_k = 32'hD5A79147;
      6'd30: round_k = 32'h06CA6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27B70A85;  6'd33: round_k = 32'h2E1B2138;
      6'd34: round_k = 32'h4D2C6DFC;  6'd35: round_k = 32'h53380D13;
      6'd36: round_k = 32'h650A7354;  6'd37: round_k = 32'h766A0ABB;
      6'd38: round_k = 32'h81C2C92E;  6'd39: round_k = 32'h92722C85;
      6'd40: round_k = 32'hA2BFE8A1;  6'd41: round_k = 32'hA81A664B;
      6'd42: round_k = 32'hC24B8B70;  6'd43: round_k = 32'hC76C51A3;
      6'd44: round_k = 32'hD192E819;  6'd45: round_k = 32'hD6990624;
      6'd46: round_k = 32'hF40E3585;  6'd47: round_k = 32'h106AA070;
      6'd48: round_k = 32'h19A4C116;  6'd49: round_k = 32'h1E376C08;
      6'd50: round_k = 32'h2748774C;  6'd51: round_k = 32'h34B0BCB5;
      6'd52: round_k = 32'h391C0CB3;  6'd53: round_k = 32'h4ED8AA4A;
      6'd54: round_k = 32'h5B9CCA4F;  6'd55: round_k = 32'h682E6FF3;
      6'd56: round_k = 32'h748F82EE;  6'd57: round_k = 32'h78A5636F;
      6'd58: round_k = 32'h84C87814;  6'd59: round_k = 32'h8CC70208;
      6'd60: round_k = 32'h90BEFFFA;  6'd61: round_k = 32'hA4506CEB;
      6'd62: round_k = 32'hBEF9A3F7;  6'd63: round_k = 32'hC67178F2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

// ===== rtl/sha224_stream_hasher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha224_stream_hasher
// SHA-224 digest over a byte stream, seven 32-bit digest words per message.
// ---------------------------------------------------------------------------
// Usage:
//   in_data carries one transaction: kind 0 appends data_byte to the
//   message, kind 1 closes the message. out_data returns the digest, most
//   significant word first, with last set on the seventh word.
//   Both channels use valid/ready; a transaction moves when both are high.
// Operation:
//   The back end takes one data byte at a time from the queue. Every 64th
//   byte also runs the block compression: 64 rounds, one per cycle, then a
//   step that adds the chain value.
//   A finish zero-fills the block one byte per cycle up to the length
//   field (in an extra block if the length does not fit), runs one or two
//   compressions, then offers one digest word per cycle unless stalled.
//   A two-entry queue in front lets input arrive while the back end works.
// Reset:
//   rst clears the queue, the byte count and the length, and loads the
//   initial chain value. A stalled receiver holds the back end in its output
//   phase; the queue keeps taking input until it is full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sha224_stream_hasher (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  s224_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output s224_pkg::out_item_t out_data
);
  import s224_pkg::*;

  logic          q_valid;
  logic          q_ready;
  work_item_t    q_item;
  queue_status_t q_status;
  core_status_t  core_status;

  s224_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .q_status (q_status)
  );

  s224_core u_core (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .core_status (core_status)
  );

  `ASSERT_SAME_CYCLE(a_ready_only_when_full, clk, rst, !in_ready, q_status.full)
  `ASSERT_SAME_CYCLE(a_round_compressing, clk, rst, |core_status.round, core_status.compressing)
  `ASSERT_NEXT_CYCLE(a_idle_after_last, clk, rst, out_valid && out_ready && out_data.last, !out_valid)

endmodule

// ===== rtl/s224_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s224_front
// Accepts input transactions, classifies them and holds them in a
// two-entry queue for the compression back end.
// ---------------------------------------------------------------------------
module s224_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  s224_pkg::in_item_t      in_data,
  output logic                    q_valid,
  input  logic                    q_ready,
  output s224_pkg::work_item_t    q_item,
  output s224_pkg::queue_status_t q_status
);
  import s224_pkg::*;

  work_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  work_item_t classified;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_status = '{full: (count == 2'd2), empty: (count == 2'd0)};

  // tag the transaction, drop the byte of a finish
  always_comb begin
    classified.is_finish = (in_data.kind == KIND_FINISH);
    classified.data_byte = classified.is_finish ? 8'h00 : in_data.data_byte;
  end

  // store payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/s224_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// s224_core
// Block buffer, padding sequencer, one-round-per-cycle SHA-256 compression
// and digest output register.
// ---------------------------------------------------------------------------
module s224_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  s224_pkg::work_item_t   q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output s224_pkg::out_item_t    out_data,
  output s224_pkg::core_status_t core_status
);
  import s224_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]   state;
  logic [511:0] blk;
  logic [5:0]   fill;
  logic [63:0]  len;
  logic [31:0]  h [8];
  logic [31:0]  r [8];
  logic [5:0]   rnd;
  logic         last_blk;
  logic         ret_pad;
  logic [2:0]   oidx;
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic         take;
  logic         emit;

  assign q_ready     = (state == ST_IDLE);
  assign take        = q_valid && q_ready;
  assign emit        = (state == ST_OUT) && (!out_valid || out_ready);
  assign core_status = '{compressing: (state == ST_COMP), round: rnd};

  // message schedule and round sums
  always_comb begin
    w_new = blk[511:480] + sig0(blk[479:448]) + blk[223:192] + sig1(blk[63:32]);
    t1 = r[7] + big1(r[4]) + ((r[4] & r[5]) ^ (~r[4] & r[6])) + round_k(rnd)
         + blk[511:480];
    t2 = big0(r[0]) + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
  end

  // hold a digest word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      len       <= '0;
      h         <= INIT_HASH;
      rnd       <= '0;
      oidx      <= '0;
      last_blk  <= 1'b0;
      ret_pad   <= 1'b0;
    end else begin
      case (state)
        // take a byte, compress a full block, or start the padding
        ST_IDLE: begin
          if (take) begin
            blk      <= {blk[503:0], q_item.is_finish ? PAD_BYTE : q_item.data_byte};
            fill     <= fill + 6'd1;
            last_blk <= 1'b0;
            ret_pad  <= q_item.is_finish;
            if (!q_item.is_finish) len <= len + 64'd1;
            if (fill == 6'd63) begin
              state <= ST_COMP;
              rnd   <= '0;
              r     <= h;
            end else if (q_item.is_finish) begin
              state <= ST_PAD;
            end
          end
        end
        // zero fill (compressing a full block if needed), then append the bit length
        ST_PAD: begin
          if (fill == LEN_POS) begin
            blk      <= {blk[447:0], len[60:0], 3'b000};
            fill     <= '0;
            last_blk <= 1'b1;
            state    <= ST_COMP;
            rnd      <= '0;
            r        <= h;
          end else begin
            blk  <= {blk[503:0], 8'h00};
            fill <= fill + 6'd1;
            if (fill == 6'd63) begin
              ret_pad <= 1'b1;
              state   <= ST_COMP;
              rnd     <= '0;
              r       <= h;
            end
          end
        end
        // one round per cycle
        ST_COMP: begin
          r[7] <= r[6];
          r[6] <= r[5];
          r[5] <= r[4];
          r[4] <= r[3] + t1;
          r[3] <= r[2];
          r[2] <= r[1];
          r[1] <= r[0];
          r[0] <= t1 + t2;
          blk  <= {blk[479:0], w_new};
          rnd  <= rnd + 6'd1;
          if (rnd == 6'd63) state <= ST_FIN;
        end
        // fold into the chain value
        ST_FIN: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + r[i];
          oidx <= '0;
          if (last_blk)     state <= ST_OUT;
          else if (ret_pad) state <= ST_PAD;
          else              state <= ST_IDLE;
        end
        // emit seven words, then reload for the next message
        ST_OUT: begin
          if (emit) begin
            out_data.digest_word <= h[oidx];
            out_data.last        <= (oidx == 3'd6);
            oidx                 <= oidx + 3'd1;
            if (oidx == 3'd6) begin
              h     <= INIT_HASH;
              len   <= '0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/sha224_stream_hasher_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha224_stream_hasher_test
// Streams directed and random messages into the hasher, computes the
// SHA-224 digest of each message alongside, and checks every digest word.
// ---------------------------------------------------------------------------
module sha224_stream_hasher_test;
  import s224_pkg::*;

  localparam int MAX_CYCLES = 400000;

  localparam logic [31:0] IV [8] = '{
    32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
    32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
  };

  localparam logic [31:0] KTAB [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  sha224_stream_hasher uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // hash state mirrored from the accepted transactions
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] msg_len;

  in_item_t  pending_items [$];
  out_item_t digest_words [$];
  int errors = 0;
  int cycle = 0;
  int words_seen = 0;
  int messages = 0;
  bit quiet_phase = 0;
  bit hold_pending = 0;
  bit hold_out = 0;
  bit sender_pause = 0;
  logic in_ready_q = 1'b0;

  function automatic logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
           + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
    for (int i = 0; i < 8; i++) r[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + KTAB[t] + w[t];
      t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      for (int i = 7; i > 0; i--) r[i] = r[i-1];
      r[4] = r[4] + t1;
      r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + r[i];
  endtask

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    fill = 0;
    msg_len = '0;
  endtask

  // advance the mirrored hash by one accepted transaction
  task automatic hash_step(in_item_t it);
    logic [63:0] bits;
    out_item_t o;
    if (it.kind == KIND_DATA) begin
      blk[fill] = it.data_byte;
      fill++;
      msg_len++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end else begin
      blk[fill] = PAD_BYTE;
      fill++;
      if (fill > 56) begin
        while (fill < 64) blk[fill++] = 8'h00;
        compress();
        fill = 0;
      end
      while (fill < 56) blk[fill++] = 8'h00;
      bits = msg_len << 3;
      for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 7; i++) begin
        o.digest_word = chain[i];
        o.last = (i == 6);
        digest_words.push_back(o);
      end
      messages++;
      clear_hash();
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH cycle %0d word %0d %s: got %h want %h",
             cycle, words_seen, what, got, want);
  endtask

  task automatic add_message(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.kind = KIND_DATA;
      it.data_byte = 8'($urandom);
      pending_items.push_back(it);
    end
    it.kind = KIND_FINISH;
    it.data_byte = 8'($urandom);
    pending_items.push_back(it);
  endtask

  function automatic bit idle_now();
    return !quiet_phase && ($urandom_range(99) < 10);
  endfunction

  // driver: offer the next pending transaction, hold it until accepted
  always @(negedge clk) begin
    bit waiting;
    waiting = in_valid && !in_ready_q;
    if (!rst) begin
      if (in_valid && in_ready_q) begin
        void'(pending_items.pop_front());
      end
      if (!waiting) begin
        if (pending_items.size() > 0 && !sender_pause && !idle_now()) begin
          in_data <= pending_items[0];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // sampled acceptance at the rising edge
  always @(posedge clk) begin
    in_ready_q <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      hash_step(in_data);
    end
  end

  // receiver readiness
  always @(negedge clk) begin
    out_ready <= !rst && !hold_out && !idle_now();
  end

  // monitor: compare each accepted digest word
  always @(posedge clk) begin
    out_item_t want;
    cycle <= cycle + 1;
    if (!rst && out_valid && out_ready) begin
      if (digest_words.size() == 0) begin
        report("unexpected word", out_data.digest_word, 32'h0);
      end else begin
        want = digest_words.pop_front();
        if (out_data.digest_word !== want.digest_word)
          report("digest_word", out_data.digest_word, want.digest_word);
        if (out_data.last !== want.last)
          report("last", 32'(out_data.last), 32'(want.last));
      end
      words_seen <= words_seen + 1;
    end
  end

  // long receiver hold-off, counted in its own process
  initial begin
    int n;
    wait (hold_pending);
    @(negedge clk);
    hold_out = 1'b1;
    n = 0;
    while (n < 400) begin
      @(negedge clk);
      n++;
    end
    hold_out = 1'b0;
  end

  // timeout
  always @(posedge clk) begin
    if (cycle > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int lens [$];
    int left;
    in_item_t it;
    clear_hash();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty, boundary lengths, extreme bytes, finish data ignored
    lens = '{0, 55, 56, 63, 64};
    it.kind = KIND_FINISH; it.data_byte = 8'hFF; pending_items.push_back(it);
    it.kind = KIND_DATA; it.data_byte = 8'h00; pending_items.push_back(it);
    it.data_byte = 8'hFF; pending_items.push_back(it);
    it.kind = KIND_FINISH; it.data_byte = 8'h00; pending_items.push_back(it);
    it.kind = KIND_DATA; it.data_byte = 8'hA5; pending_items.push_back(it);
    it.kind = KIND_FINISH; it.data_byte = 8'h5A; pending_items.push_back(it);
    foreach (lens[i]) add_message(lens[i]);

    // random messages, a quiet stretch with no idling in the middle
    left = 460 - pending_items.size();
    while (left > 0) begin
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
      if (n + 1 > left) n = left > 1 ? left - 1 : 0;
      add_message(n);
      left -= n + 1;
      if (pending_items.size() > 150 && pending_items.size() < 200) quiet_phase = 1;
    end

    // stall the receiver early while the sender keeps offering
    hold_pending = 1'b1;
    wait (pending_items.size() < 200);
    quiet_phase = 1'b0;
    // pause the sender until every digest has drained
    wait (pending_items.size() < 120 && pending_items[0].kind == KIND_DATA);
    sender_pause = 1'b1;
    wait (digest_words.size() == 0 && !hold_out);
    repeat (20) @(negedge clk);
    sender_pause = 1'b0;

    wait (pending_items.size() == 0 && !in_valid);
    wait (digest_words.size() == 0);
    repeat (300) @(posedge clk);
    $display("covered %0d messages, %0d digest words checked", messages, words_seen);
    if (errors == 0 && digest_words.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/s224_pkg.sv
rtl/s224_front.sv
rtl/s224_core.sv
rtl/sha224_stream_hasher.sv
sim/sha224_stream_hasher_test.sv
